/* hw/rtl/crtq_pkg.sv */
// Shared constants and types for the circular ready task queue.
package crtq_pkg;

   // Default number of task slots in the link table.
   localparam int unsigned NUM_TASKS_DEF = 16;

   // Fixed field widths of the request and response words.
   localparam int unsigned CMD_W    = 2;
   localparam int unsigned TASK_W   = 4;
   localparam int unsigned STATUS_W = 2;

   typedef logic [CMD_W-1:0]    cmd_type;
   typedef logic [STATUS_W-1:0] status_type;

   // Command codes.
   localparam cmd_type CMD_ADD    = 2'd0;
   localparam cmd_type CMD_REMOVE = 2'd1;
   localparam cmd_type CMD_TAKE   = 2'd2;

   // Status codes.
   localparam status_type ST_OK     = 2'd0;
   localparam status_type ST_QUEUED = 2'd1;
   localparam status_type ST_ABSENT = 2'd2;
   localparam status_type ST_EMPTY  = 2'd3;

   // Outcome of one predecessor search cycle.
   typedef struct packed {
      logic hit;
      logic miss;
   } scan_stat_type;

endpackage

/* hw/rtl/crtq_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module crtq_ram #(
   parameter int unsigned WIDTH = 4,
   parameter int unsigned DEPTH = 16,
   localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port; the read data is registered.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/crtq_scan.sv */
// Predecessor search: walks the link table one entry per cycle.
module crtq_scan #(
   parameter int unsigned NUM_TASKS = crtq_pkg::NUM_TASKS_DEF,
   localparam int unsigned IDX_W = $clog2(NUM_TASKS)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [IDX_W-1:0]        target,
   input  logic [NUM_TASKS-1:0]    valid_vec,
   input  logic [IDX_W-1:0]        rd_data,
   output logic                    rd_en,
   output logic [IDX_W-1:0]        rd_addr,
   output crtq_pkg::scan_stat_type stat,
   output logic [IDX_W-1:0]        hit_idx
);

   import crtq_pkg::*;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_TASKS - 1);

   logic             issue_ff, issue_in;
   logic             pend_ff, pend_in;
   logic [IDX_W-1:0] scan_ff, scan_in;
   logic [IDX_W-1:0] prev_ff, prev_in;
   logic             match;

   // The word returning now belongs to the entry read in the previous cycle.
   assign match = pend_ff && valid_vec[prev_ff] && (rd_data == target);

   assign rd_en     = issue_ff;
   assign rd_addr   = scan_ff;
   assign hit_idx   = prev_ff;
   assign stat.hit  = match;
   assign stat.miss = pend_ff && !match && (prev_ff == LAST_IDX);

   // Address sequencing; stops on the first matching entry or after the last entry.
   always_comb begin
      issue_in = issue_ff;
      pend_in  = issue_ff;
      scan_in  = scan_ff;
      prev_in  = scan_ff;
      if (start) begin
         issue_in = 1'b1;
         pend_in  = 1'b0;
         scan_in  = '0;
      end else if (match) begin
         issue_in = 1'b0;
         pend_in  = 1'b0;
      end else if (issue_ff) begin
         scan_in  = scan_ff + 1'b1;
         issue_in = (scan_ff != LAST_IDX);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         issue_ff <= 1'b0;
         pend_ff  <= 1'b0;
      end else begin
         issue_ff <= issue_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff <= scan_in;
      prev_ff <= prev_in;
   end

endmodule

/* hw/rtl/circular_ready_task_queue.sv */
// Round-robin ready queue of task numbers kept as a circular linked list.
//
// The queue holds task numbers in a circular singly linked list whose links
// live in a RAM with registered read data, indexed by task; queued flags sit in
// flip-flops and reset clears them at once, so the block takes a request as
// soon as reset is released. One request word is in work at a time. Removal
// walks the link RAM through its single read port, one entry a cycle, to find
// the predecessor of the task. A finished response word waits in an output
// register, so the next request is taken while the previous response is still
// stalled.
module circular_ready_task_queue #(
   parameter int unsigned NUM_TASKS = crtq_pkg::NUM_TASKS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [crtq_pkg::CMD_W-1:0]       req_command,
   input  logic [crtq_pkg::TASK_W-1:0]      req_task_req,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [crtq_pkg::STATUS_W-1:0]    rsp_status,
   output logic [crtq_pkg::TASK_W-1:0]      rsp_next_task
);

   import crtq_pkg::*;

   localparam int unsigned IDX_W = $clog2(NUM_TASKS);

   typedef enum logic [7:0] {
      S_IDLE     = 8'b0000_0001,
      S_TAKE     = 8'b0000_0010,
      S_ADD_LINK = 8'b0000_0100,
      S_ADD_TAIL = 8'b0000_1000,
      S_RM_HEAD  = 8'b0001_0000,
      S_SCAN     = 8'b0010_0000,
      S_UNLINK   = 8'b0100_0000,
      S_RESP     = 8'b1000_0000
   } state_type;

   state_type            state_ff, state_in;
   logic [NUM_TASKS-1:0] queued_ff, queued_in;
   logic                 tail_ok_ff, tail_ok_in;
   logic [IDX_W-1:0]     tail_ff, tail_in;
   logic [IDX_W-1:0]     task_ff, task_in;
   logic [IDX_W-1:0]     succ_ff, succ_in;
   logic [IDX_W-1:0]     pred_ff, pred_in;
   status_type           res_status_ff, res_status_in;
   logic [TASK_W-1:0]    res_task_ff, res_task_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   status_type           rsp_status_ff, rsp_status_in;
   logic [TASK_W-1:0]    rsp_task_ff, rsp_task_in;

   logic                 req_fire;
   logic                 req_in_range;
   logic [IDX_W-1:0]     req_idx;
   logic                 out_free;

   logic                 ram_wr_en;
   logic [IDX_W-1:0]     ram_wr_addr;
   logic [IDX_W-1:0]     ram_wr_data;
   logic                 ram_rd_en;
   logic [IDX_W-1:0]     ram_rd_addr;
   logic [IDX_W-1:0]     ram_rd_data;

   logic                 scan_start;
   logic                 scan_rd_en;
   logic [IDX_W-1:0]     scan_rd_addr;
   scan_stat_type        scan_stat;
   logic [IDX_W-1:0]     scan_hit_idx;

   // Link storage: entry i holds the task that follows task i.
   crtq_ram #(
      .WIDTH (IDX_W),
      .DEPTH (NUM_TASKS)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Search for the entry that links to the task being removed.
   crtq_scan #(
      .NUM_TASKS (NUM_TASKS)
   ) u_scan (
      .clock     (clock),
      .reset     (reset),
      .start     (scan_start),
      .target    (task_ff),
      .valid_vec (queued_ff),
      .rd_data   (ram_rd_data),
      .rd_en     (scan_rd_en),
      .rd_addr   (scan_rd_addr),
      .stat      (scan_stat),
      .hit_idx   (scan_hit_idx)
   );

   // Request handshake and decode.
   assign req_stall    = (state_ff != S_IDLE);
   assign req_fire     = req_valid && !req_stall;
   assign req_idx      = IDX_W'(req_task_req);
   assign req_in_range = (32'(req_task_req) < NUM_TASKS);
   assign out_free     = !rsp_valid_ff || !rsp_stall;

   // Command sequencer.
   always_comb begin
      state_in      = state_ff;
      queued_in     = queued_ff;
      tail_ok_in    = tail_ok_ff;
      tail_in       = tail_ff;
      task_in       = task_ff;
      succ_in       = succ_ff;
      pred_in       = pred_ff;
      res_status_in = res_status_ff;
      res_task_in   = res_task_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = task_ff;
      ram_wr_data   = task_ff;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = tail_ff;
      scan_start    = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               task_in       = req_idx;
               res_status_in = ST_OK;
               res_task_in   = '0;
               state_in      = S_RESP;
               case (req_command)
                  CMD_TAKE: begin
                     if (!tail_ok_ff) begin
                        res_status_in = ST_EMPTY;
                     end else begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = tail_ff;
                        state_in    = S_TAKE;
                     end
                  end
                  CMD_ADD: begin
                     if (!req_in_range) begin
                        res_status_in = ST_ABSENT;
                     end else if (queued_ff[req_idx]) begin
                        res_status_in = ST_QUEUED;
                     end else if (!tail_ok_ff) begin
                        // First task links to itself.
                        ram_wr_en          = 1'b1;
                        ram_wr_addr        = req_idx;
                        ram_wr_data        = req_idx;
                        queued_in[req_idx] = 1'b1;
                        tail_in            = req_idx;
                        tail_ok_in         = 1'b1;
                     end else begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = tail_ff;
                        state_in    = S_ADD_LINK;
                     end
                  end
                  CMD_REMOVE: begin
                     if (!req_in_range || !queued_ff[req_idx]) begin
                        res_status_in = ST_ABSENT;
                     end else begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = req_idx;
                        state_in    = S_RM_HEAD;
                     end
                  end
                  default: begin
                     res_status_in = ST_OK;
                  end
               endcase
            end
         end
         S_TAKE: begin
            tail_in     = ram_rd_data;
            res_task_in = TASK_W'(ram_rd_data);
            state_in    = S_RESP;
         end
         S_ADD_LINK: begin
            // New task inherits the head that followed the tail.
            ram_wr_en   = 1'b1;
            ram_wr_addr = task_ff;
            ram_wr_data = ram_rd_data;
            state_in    = S_ADD_TAIL;
         end
         S_ADD_TAIL: begin
            ram_wr_en          = 1'b1;
            ram_wr_addr        = tail_ff;
            ram_wr_data        = task_ff;
            tail_in            = task_ff;
            queued_in[task_ff] = 1'b1;
            state_in           = S_RESP;
         end
         S_RM_HEAD: begin
            succ_in = ram_rd_data;
            if (ram_rd_data == task_ff) begin
               // Only task in the queue: the queue becomes empty.
               tail_ok_in         = 1'b0;
               tail_in            = '0;
               queued_in[task_ff] = 1'b0;
               state_in           = S_RESP;
            end else begin
               scan_start = 1'b1;
               state_in   = S_SCAN;
            end
         end
         S_SCAN: begin
            ram_rd_en   = scan_rd_en;
            ram_rd_addr = scan_rd_addr;
            if (scan_stat.hit) begin
               pred_in  = scan_hit_idx;
               state_in = S_UNLINK;
            end else if (scan_stat.miss) begin
               queued_in[task_ff] = 1'b0;
               state_in           = S_RESP;
            end
         end
         S_UNLINK: begin
            ram_wr_en          = 1'b1;
            ram_wr_addr        = pred_ff;
            ram_wr_data        = succ_ff;
            queued_in[task_ff] = 1'b0;
            if (tail_ok_ff && (tail_ff == task_ff)) begin
               tail_in = pred_ff;
            end
            state_in = S_RESP;
         end
         S_RESP: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Output register: loads when the sequencer finishes and the slot is free.
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_task_in   = rsp_task_ff;
      if ((state_ff == S_RESP) && out_free) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = res_status_ff;
         rsp_task_in   = res_task_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         queued_ff    <= '0;
         tail_ok_ff   <= 1'b0;
         tail_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         queued_ff    <= queued_in;
         tail_ok_ff   <= tail_ok_in;
         tail_ff      <= tail_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      task_ff       <= task_in;
      succ_ff       <= succ_in;
      pred_ff       <= pred_in;
      res_status_ff <= res_status_in;
      res_task_ff   <= res_task_in;
      rsp_status_ff <= rsp_status_in;
      rsp_task_ff   <= rsp_task_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_next_task = rsp_task_ff;

endmodule

/* hw/rtl/crtq_check.sv */
// Port-level checks for the circular ready task queue, bound to the top level.
module crtq_check (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic [crtq_pkg::CMD_W-1:0]    req_command,
   input logic [crtq_pkg::TASK_W-1:0]   req_task_req,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [crtq_pkg::STATUS_W-1:0] rsp_status,
   input logic [crtq_pkg::TASK_W-1:0]   rsp_next_task
);

   import crtq_pkg::*;

   // One request word is in work at a time.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request taken while the previous one is still in work");

   // A stalled response word holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_status)
                                    && $stable(rsp_next_task)))
      else $error("stalled response word changed");

   // Only a successful take carries a task number.
   a_task_zero_on_error: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != ST_OK)) |-> (rsp_next_task == '0))
      else $error("task number present on an error response");

   // After reset the block is ready and has nothing to deliver.
   a_reset_state: assert property (@(posedge clock)
      reset |=> (!rsp_valid && !req_stall))
      else $error("block not idle after reset");

endmodule

bind circular_ready_task_queue crtq_check u_crtq_check (.*);
